// ----- sv/lgs_pkg.sv -----
// shared constants and helpers for the life generation step unit
// no dependencies; imported by every module of the block
package lgs_pkg;

  // one board row is one word of this many cells
  localparam int unsigned RowW = 64;
  // width of the column count register
  localparam int unsigned ColsW = 7;
  // column count after reset
  localparam logic [ColsW-1:0] ColsReset = 7'd64;
  // default board limits
  localparam int unsigned MaxRowsDef = 64;
  localparam int unsigned MaxColsDef = 64;

  // mask that keeps columns below cols
  function automatic logic [RowW-1:0] col_mask(input logic [ColsW-1:0] cols);
    logic [RowW-1:0] m;
    for (int c = 0; c < RowW; c++) begin
      m[c] = (ColsW'(c) < cols);
    end
    return m;
  endfunction

endpackage

// ----- sv/life_generation_step_unit.sv -----
// top level: row loading, generation sequencer and output register
// depends on lgs_pkg, lgs_row_store and lgs_next_row
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+-------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata row_cells, tlast row_last
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata next_row_cells, tlast out_last
//  config    | in  | board_columns_we_i           | board_columns_i
//
// rows load one per cycle into the row store while it is in its load state. a
// word with tlast starts the generation pass: the StPrime and StFill states
// prime the read pipeline, then one output word per cycle, while the output is
// not stalled, comes through the single store read port. reset clears the row
// count and the sequencer; the store itself is not cleared. a stalled output holds
// the pass in place, and input is taken again as soon as the last output word sits in the output register.
module life_generation_step_unit
  import lgs_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MaxRowsDef,
  parameter int unsigned MAX_COLS = MaxColsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             board_columns_we_i,
  input  logic [ColsW-1:0] board_columns_i,
  // input rows
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [RowW-1:0]  s_axis_tdata,   // [63:0] row_cells
  input  logic             s_axis_tlast,   // row_last
  // output rows
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [RowW-1:0]  m_axis_tdata,   // [63:0] next_row_cells
  output logic             m_axis_tlast    // out_last
);

  localparam int unsigned CntW = $clog2(MAX_ROWS + 1);
  localparam int unsigned IdxW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ExtW = CntW + 1;

  localparam logic [1:0] StLoad  = 2'd0;
  localparam logic [1:0] StPrime = 2'd1;
  localparam logic [1:0] StFill  = 2'd2;
  localparam logic [1:0] StStep  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [ColsW-1:0] cols_q;
  logic [CntW-1:0]  rows_loaded_q, rows_loaded_d;
  logic [CntW-1:0]  m_q, m_d;
  logic [CntW-1:0]  i_q, i_d;
  logic [RowW-1:0]  up_q, up_d, cur_q, cur_d;
  logic             out_valid_q, out_valid_d;
  logic [RowW-1:0]  out_data_q, out_data_d;
  logic             out_last_q, out_last_d;

  logic             in_acc, store_full, wr_en;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic [RowW-1:0]  rd_data, dn_raw, mask, next_row;
  logic [ColsW-1:0] cols_sat;
  logic [ExtW-1:0]  i1, i2, m_ext;
  logic             go, last_row;

  // column count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ColsReset;
    end else if (board_columns_we_i) begin
      cols_q <= board_columns_i;
    end
  end

  assign cols_sat = (cols_q > ColsW'(MAX_COLS)) ? ColsW'(MAX_COLS) : cols_q;
  assign mask     = col_mask(cols_sat);

  // load side
  assign s_axis_tready = (state_q == StLoad);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign store_full    = (rows_loaded_q >= CntW'(MAX_ROWS));
  assign wr_en         = in_acc && !store_full;

  // window indexes
  assign i1       = ExtW'(i_q) + ExtW'(1);
  assign i2       = ExtW'(i_q) + ExtW'(2);
  assign m_ext    = ExtW'(m_q);
  assign last_row = (i1 == m_ext);
  assign dn_raw   = (i1 < m_ext) ? rd_data : '0;
  assign go       = !out_valid_q || m_axis_tready;

  // row store; loading and the pass never overlap, so no forwarding
  lgs_row_store #(
    .Depth (MAX_ROWS),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (rows_loaded_q[IdxW-1:0]),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // rule for the current row
  lgs_next_row u_rule (
    .up_i   (up_q & mask),
    .cur_i  (cur_q & mask),
    .dn_i   (dn_raw & mask),
    .next_o (next_row)
  );

  // sequencer
  always_comb begin
    state_d       = state_q;
    rows_loaded_d = rows_loaded_q;
    m_d           = m_q;
    i_d           = i_q;
    up_d          = up_q;
    cur_d         = cur_q;
    rd_en         = 1'b0;
    rd_addr       = '0;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_data_d    = out_data_q;
    out_last_d    = out_last_q;
    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (!store_full) begin
            rows_loaded_d = rows_loaded_q + CntW'(1);
          end
          if (s_axis_tlast) begin
            m_d           = rows_loaded_d;
            rows_loaded_d = '0;
            state_d       = StPrime;
          end
        end
      end
      StPrime: begin
        // fetch the first row
        rd_en   = 1'b1;
        rd_addr = '0;
        state_d = StFill;
      end
      StFill: begin
        // first row arrives; fetch the second if there is one
        cur_d   = rd_data;
        up_d    = '0;
        i_d     = '0;
        rd_en   = (m_ext > ExtW'(1));
        rd_addr = IdxW'(1);
        state_d = StStep;
      end
      StStep: begin
        if (go) begin
          out_valid_d = 1'b1;
          out_data_d  = next_row & mask;
          out_last_d  = last_row;
          up_d        = cur_q;
          cur_d       = dn_raw;
          rd_en       = (i2 < m_ext);
          rd_addr     = i2[IdxW-1:0];
          i_d         = i1[CntW-1:0];
          if (last_row) begin
            state_d = StLoad;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StLoad;
      rows_loaded_q <= '0;
      m_q           <= '0;
      i_q           <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      rows_loaded_q <= rows_loaded_d;
      m_q           <= m_d;
      i_q           <= i_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // window and output payload
  always_ff @(posedge clk_i) begin
    up_q       <= up_d;
    cur_q      <= cur_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // row index stays inside the loaded board during the pass
  a_idx_in_board: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StStep) |-> (ExtW'(i_q) < m_ext))
    else $error("row index past end of board");

  // a pass always covers at least one row
  a_board_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPrime) |-> (m_q != '0))
    else $error("generation pass started on empty board");

  // the row count never exceeds the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_loaded_q <= CntW'(MAX_ROWS))
    else $error("row count beyond store depth");

  // cells beyond the column count are dead on output
  a_cols_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && $stable(cols_q)) |-> ((m_axis_tdata & ~mask) == '0))
    else $error("live cell outside the board columns");

endmodule

// ----- sv/lgs_row_store.sv -----
// row store: one write port, one read port, registered read data
// depends on lgs_pkg for the row width
module lgs_row_store
  import lgs_pkg::*;
#(
  parameter int unsigned Depth = MaxRowsDef,
  parameter int unsigned IdxW  = 6
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [RowW-1:0] wr_data_i,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic [RowW-1:0] rd_data_o
);

  logic [RowW-1:0] mem_q [Depth];
  logic [RowW-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/lgs_next_row.sv -----
// b3/s23 rule for one row, given the rows above and below
// depends on lgs_pkg for the row width
module lgs_next_row
  import lgs_pkg::*;
(
  input  logic [RowW-1:0] up_i,
  input  logic [RowW-1:0] cur_i,
  input  logic [RowW-1:0] dn_i,
  output logic [RowW-1:0] next_o
);

  localparam logic [3:0] NbrBirth   = 4'd3;
  localparam logic [3:0] NbrSurvive = 4'd2;

  // rows padded with a dead cell on each side
  logic [RowW+1:0] up_x, cur_x, dn_x;

  assign up_x  = {1'b0, up_i, 1'b0};
  assign cur_x = {1'b0, cur_i, 1'b0};
  assign dn_x  = {1'b0, dn_i, 1'b0};

  // one lane per column: count the eight neighbors, apply the rule
  for (genvar c = 0; c < RowW; c++) begin : g_lane
    logic [3:0] nbr;
    assign nbr = 4'(up_x[c]) + 4'(up_x[c+1]) + 4'(up_x[c+2])
               + 4'(cur_x[c]) + 4'(cur_x[c+2])
               + 4'(dn_x[c]) + 4'(dn_x[c+1]) + 4'(dn_x[c+2]);
    assign next_o[c] = (nbr == NbrBirth) || (cur_i[c] && (nbr == NbrSurvive));
  end

endmodule

// ----- test/life_generation_step_unit_tb.sv -----
// self-checking testbench for life_generation_step_unit: directed boards, then random boards
// checked against a local next-generation predictor, with random stalls on both streams
// depends on lgs_pkg and the life_generation_step_unit rtl
module life_generation_step_unit_tb
  import lgs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxRows   = MaxRowsDef;
  localparam int unsigned MaxCols   = MaxColsDef;
  localparam int unsigned SettleCyc = 12;
  localparam int unsigned HoldAt    = 120;
  localparam int unsigned HoldCyc   = 400;
  localparam int unsigned RowTarget = 350;
  localparam int unsigned CycLimit  = 200000;
  localparam logic [RowW-1:0] AllOnes  = {RowW{1'b1}};
  localparam logic [RowW-1:0] EdgesOff = 64'h7FFF_FFFF_FFFF_FFFE;

  // one emitted word of the next generation
  typedef struct packed {
    logic [RowW-1:0] cells;
    logic            last;
  } gen_row_t;

  // one directed stimulus row; the column write goes ahead of the row
  typedef struct packed {
    bit               cols_we;
    logic [ColsW-1:0] cols_val;
    logic [RowW-1:0]  cells;
    bit               last;
    bit               typed;
    logic [RowW-1:0]  typed_cells;
  } plan_row_t;

  localparam int unsigned PlanLen = 23;
  localparam plan_row_t Plan [PlanLen] = '{
    // single-row boards with results known by hand
    '{1'b0, 7'd0,   64'h0,                  1'b1, 1'b1, 64'h0},
    '{1'b1, 7'd64,  AllOnes,                1'b1, 1'b1, EdgesOff},
    '{1'b1, 7'd0,   AllOnes,                1'b1, 1'b1, 64'h0},
    '{1'b1, 7'd127, AllOnes,                1'b1, 1'b1, EdgesOff},
    '{1'b1, 7'd1,   AllOnes,                1'b1, 1'b1, 64'h0},
    '{1'b1, 7'd2,   AllOnes,                1'b1, 1'b1, 64'h0},
    // vertical blinker on a three-column board
    '{1'b1, 7'd3,   64'h2,                  1'b0, 1'b0, 64'h0},
    '{1'b0, 7'd0,   64'h2,                  1'b0, 1'b0, 64'h0},
    '{1'b0, 7'd0,   64'h2,                  1'b1, 1'b0, 64'h0},
    // live cells on both outer columns, no wrap-around
    '{1'b1, 7'd64,  64'hC000_0000_0000_0000, 1'b0, 1'b0, 64'h0},
    '{1'b0, 7'd0,   64'hC000_0000_0000_0001, 1'b0, 1'b0, 64'h0},
    '{1'b0, 7'd0,   64'h8000_0000_0000_0001, 1'b1, 1'b0, 64'h0},
    // cells above the column count are ignored
    '{1'b1, 7'd8,   64'hFFFF_FFFF_FFFF_FF00, 1'b0, 1'b0, 64'h0},
    '{1'b0, 7'd0,   64'hFFFF_FFFF_FFFF_FF3C, 1'b0, 1'b0, 64'h0},
    '{1'b0, 7'd0,   64'hFFFF_FFFF_FFFF_FF00, 1'b1, 1'b0, 64'h0},
    // checkerboard
    '{1'b1, 7'd64,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'h0},
    '{1'b0, 7'd0,   64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0},
    '{1'b0, 7'd0,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'h0},
    '{1'b0, 7'd0,   64'h5555_5555_5555_5555, 1'b1, 1'b0, 64'h0},
    // glider on a ten-column board
    '{1'b1, 7'd10,  64'h2,                  1'b0, 1'b0, 64'h0},
    '{1'b0, 7'd0,   64'h4,                  1'b0, 1'b0, 64'h0},
    '{1'b0, 7'd0,   64'h7,                  1'b0, 1'b0, 64'h0},
    '{1'b0, 7'd0,   64'h0,                  1'b1, 1'b0, 64'h0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             board_columns_we_i;
  logic [ColsW-1:0] board_columns_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [RowW-1:0]  s_axis_tdata;   // [63:0] row_cells
  logic             s_axis_tlast;   // row_last
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [RowW-1:0]  m_axis_tdata;   // [63:0] next_row_cells
  logic             m_axis_tlast;   // out_last

  // predictor state
  logic [RowW-1:0]  board_copy [MaxRows];
  int unsigned      rows_kept;
  logic [ColsW-1:0] cols_setting;
  gen_row_t         next_gen_rows [$];

  int unsigned rows_sent;
  int unsigned gen_mismatches;
  int unsigned cyc_count;
  int unsigned hold_left;
  bit          hold_done;

  life_generation_step_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .board_columns_we_i (board_columns_we_i),
    .board_columns_i    (board_columns_i),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .s_axis_tlast       (s_axis_tlast),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata),
    .m_axis_tlast       (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // idle roll shared by both streams, off during the calm window
  function automatic bit idle_roll();
    if (rows_sent >= 200 && rows_sent < 270) return 1'b0;
    return $urandom_range(99) < 29;
  endfunction

  // long receiver hold-off about to start or still running
  function automatic bit hold_pending();
    return (rows_sent >= HoldAt) && (!hold_done || hold_left != 0);
  endfunction

  // cell of a row, dead outside the board
  function automatic int unsigned cell_of(input logic [RowW-1:0] w, input int c);
    if (c < 0 || c >= int'(RowW)) return 0;
    return int'(w[c]);
  endfunction

  // store a row; on the last row queue the whole next generation
  task automatic advance_board(input logic [RowW-1:0] cells, input bit last);
    logic [RowW-1:0] keep, cur, up, dn, nxt;
    int unsigned     cols, n;
    if (rows_kept < MaxRows) begin
      board_copy[rows_kept] = cells;
      rows_kept++;
    end
    if (!last) return;
    cols = (cols_setting > MaxCols) ? MaxCols : cols_setting;
    keep = (cols >= RowW) ? AllOnes : ((64'd1 << cols) - 64'd1);
    for (int i = 0; i < int'(rows_kept); i++) begin
      cur = board_copy[i] & keep;
      up  = (i > 0) ? (board_copy[i-1] & keep) : '0;
      dn  = (i + 1 < int'(rows_kept)) ? (board_copy[i+1] & keep) : '0;
      nxt = '0;
      for (int c = 0; c < int'(RowW); c++) begin
        n = 0;
        for (int k = -1; k <= 1; k++) begin
          n += cell_of(up, c + k) + cell_of(dn, c + k);
          if (k != 0) n += cell_of(cur, c + k);
        end
        if (n == 3 || (cur[c] && n == 2)) nxt[c] = 1'b1;
      end
      next_gen_rows.push_back('{nxt & keep, (i + 1 == int'(rows_kept))});
    end
    rows_kept = 0;
  endtask

  // offer one word and wait for it to be taken; called just after a rising edge
  task automatic send_row(input logic [RowW-1:0] cells, input bit last,
                          input bit typed, input logic [RowW-1:0] typed_cells);
    while (idle_roll()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cells;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    rows_sent++;
    advance_board(cells, last);
    // single-row board with a hand-worked result
    if (typed) begin
      void'(next_gen_rows.pop_back());
      next_gen_rows.push_back('{typed_cells, 1'b1});
    end
  endtask

  // wait until the block is idle, then write the column count
  task automatic write_cols(input logic [ColsW-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (next_gen_rows.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    board_columns_we_i <= 1'b1;
    board_columns_i    <= val;
    cols_setting = val;
    @(posedge clk_i);
    board_columns_we_i <= 1'b0;
  endtask

  // random row content with varied density
  function automatic logic [RowW-1:0] random_row();
    logic [RowW-1:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return a & b;
      1: return a | b;
      2: return AllOnes;
      3: return '0;
      default: return a;
    endcase
  endfunction

  // random column count, extremes favored
  function automatic logic [ColsW-1:0] random_cols();
    case ($urandom_range(7))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd63;
      3: return 7'd64;
      4: return 7'd65;
      5: return 7'd127;
      default: return ColsW'($urandom_range(127, 1));
    endcase
  endfunction

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (!hold_done && rows_sent >= HoldAt) begin
      hold_done = 1'b1;
      hold_left = HoldCyc;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !idle_roll();
    end
  end

  // compare each output word with the oldest expectation
  always @(posedge clk_i) begin
    gen_row_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (next_gen_rows.size() == 0) begin
        gen_mismatches++;
        $display("%0t unexpected word: cells %h last %b", $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = next_gen_rows.pop_front();
        if (m_axis_tdata !== want.cells) begin
          gen_mismatches++;
          $display("%0t cells mismatch: expected %h actual %h", $time, want.cells,
                   m_axis_tdata);
        end
        if (m_axis_tlast !== want.last) begin
          gen_mismatches++;
          $display("%0t last mismatch: expected %b actual %b", $time, want.last,
                   m_axis_tlast);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cyc_count++;
    if (cyc_count > CycLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned len;
    rows_kept      = 0;
    cols_setting   = ColsReset;
    rows_sent      = 0;
    gen_mismatches = 0;
    cyc_count      = 0;
    hold_left      = 0;
    hold_done      = 1'b0;
    rst_ni             <= 1'b0;
    board_columns_we_i <= 1'b0;
    board_columns_i    <= '0;
    s_axis_tvalid      <= 1'b0;
    s_axis_tdata       <= '0;
    s_axis_tlast       <= 1'b0;
    m_axis_tready      <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed boards
    foreach (Plan[i]) begin
      if (Plan[i].cols_we) write_cols(Plan[i].cols_val);
      send_row(Plan[i].cells, Plan[i].last, Plan[i].typed, Plan[i].typed_cells);
    end

    // random boards; the first overflows the store and ends on a dropped row
    // no column write around the hold-off, so the sender keeps pushing rows
    len = 66;
    while (rows_sent < RowTarget) begin
      if (!hold_pending() && $urandom_range(99) < 30) write_cols(random_cols());
      for (int r = 0; r < int'(len); r++) begin
        send_row(random_row(), r == int'(len) - 1, 1'b0, '0);
      end
      case ($urandom_range(99)) inside
        [0:59]:  len = $urandom_range(6, 1);
        [60:89]: len = $urandom_range(24, 7);
        [90:95]: len = $urandom_range(64, 60);
        default: len = $urandom_range(70, 65);
      endcase
    end

    // drain
    s_axis_tvalid <= 1'b0;
    while (next_gen_rows.size() != 0) @(posedge clk_i);
    repeat (SettleCyc * 2) @(posedge clk_i);
    if (gen_mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/lgs_pkg.sv
sv/lgs_row_store.sv
sv/lgs_next_row.sv
sv/life_generation_step_unit.sv
test/life_generation_step_unit_tb.sv
